/* hw/rtl/lrce_pkg.sv */
// Shared types, constants and lookup functions of the label raster column encoder.
// Used by every module under hw/rtl; depends on nothing else.
package lrce_pkg;

    localparam int HEAD_DOTS   = 128;
    localparam int PIX_BITS    = 128;
    localparam int ROW_BYTES   = (HEAD_DOTS + 7) / 8;
    localparam int ROW_BITS    = ROW_BYTES * 8;
    localparam int ROW_LEN     = ROW_BYTES + 4;
    localparam int HEADER_LEN  = 14;
    localparam int SEQ_LEN     = (ROW_LEN > HEADER_LEN) ? ROW_LEN : HEADER_LEN;
    localparam int STEP_W      = $clog2(SEQ_LEN);
    localparam int ROW_IDX_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int EXT_W       = PIX_BITS + ROW_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // input modes
    localparam logic [1:0] MODE_JOB    = 2'd0;
    localparam logic [1:0] MODE_LABEL  = 2'd1;
    localparam logic [1:0] MODE_COLUMN = 2'd2;
    localparam logic [1:0] MODE_END    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_HEIGHT = 2'd1;
    localparam logic [1:0] ST_LENGTH = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MIRROR  = 2'd0;
    localparam logic [1:0] CFG_AUTOCUT = 2'd1;
    localparam logic [1:0] CFG_MEDIA   = 2'd2;

    localparam logic [7:0] MEDIA_RESET = 8'd12;
    localparam logic [7:0] MEDIA_FULL  = 8'd24;

    // stream bytes
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_I         = 8'h69;
    localparam logic [7:0] CH_M         = 8'h4D;
    localparam logic [7:0] CH_K         = 8'h4B;
    localparam logic [7:0] CH_R         = 8'h52;
    localparam logic [7:0] CH_G         = 8'h47;
    localparam logic [7:0] CH_Z         = 8'h5A;
    localparam logic [7:0] BYTE_EOJ     = 8'h1A;
    localparam logic [7:0] BYTE_FF      = 8'h0C;
    localparam logic [7:0] BIT_AUTOCUT  = 8'h40;
    localparam logic [7:0] BIT_MIRROR   = 8'h80;
    localparam logic [7:0] ROW_CNT_LO   = 8'((ROW_BYTES + 1) % 256);
    localparam logic [7:0] ROW_CNT_HI   = 8'((ROW_BYTES + 1) / 256);
    localparam logic [7:0] ROW_CNT_LAST = 8'(ROW_BYTES - 1);

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] dots_low;
        logic [63:0] dots_high;
        logic [7:0]  label_height;
        logic [15:0] label_length;
        logic        final_label;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef enum logic [1:0] {
        OP_HEADER,
        OP_STATUS,
        OP_BYTE,
        OP_ROW
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [7:0]          data_byte;
        logic [1:0]          status;
        logic [ROW_BITS-1:0] row;
    } t_cmd;

    // printable dots across the tape, from the tape width in mm
    function automatic logic [7:0] pixel_width(input logic [7:0] w);
        logic [7:0] pw;
        if (w >= MEDIA_FULL) begin
            pw = 8'(HEAD_DOTS);
        end else begin
            unique case (w[4:0])
                5'd0:    pw = 8'd0;
                5'd1:    pw = 8'd5;
                5'd2:    pw = 8'd12;
                5'd3:    pw = 8'd19;
                5'd4:    pw = 8'd26;
                5'd5:    pw = 8'd33;
                5'd6:    pw = 8'd40;
                5'd7:    pw = 8'd47;
                5'd8:    pw = 8'd54;
                5'd9:    pw = 8'd61;
                5'd10:   pw = 8'd68;
                5'd11:   pw = 8'd75;
                5'd12:   pw = 8'd83;
                5'd13:   pw = 8'd90;
                5'd14:   pw = 8'd97;
                5'd15:   pw = 8'd104;
                5'd16:   pw = 8'd111;
                5'd17:   pw = 8'd118;
                5'd18:   pw = 8'd125;
                5'd19:   pw = 8'd132;
                5'd20:   pw = 8'd139;
                5'd21:   pw = 8'd146;
                5'd22:   pw = 8'd153;
                5'd23:   pw = 8'd160;
                default: pw = 8'd0;
            endcase
        end
        return pw;
    endfunction

    // job header, mode byte substituted at its place
    function automatic logic [7:0] header_byte(input logic [STEP_W-1:0] idx,
                                               input logic [7:0] mode_byte);
        logic [7:0] b;
        unique case (idx)
            STEP_W'(0):  b = CH_ESC;
            STEP_W'(1):  b = CH_I;
            STEP_W'(2):  b = CH_M;
            STEP_W'(3):  b = mode_byte;
            STEP_W'(4):  b = CH_ESC;
            STEP_W'(5):  b = CH_I;
            STEP_W'(6):  b = CH_K;
            STEP_W'(7):  b = 8'h00;
            STEP_W'(8):  b = CH_ESC;
            STEP_W'(9):  b = CH_I;
            STEP_W'(10): b = CH_R;
            STEP_W'(11): b = 8'h01;
            STEP_W'(12): b = CH_M;
            STEP_W'(13): b = 8'h02;
            default:     b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/lrce_front.sv */
// Front end: configuration registers, label state and item classification.
// Depends on lrce_pkg; feeds lrce_queue with one command per accepted word.
module lrce_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lrce_pkg::t_item      i_item,
    output logic                 o_accept,
    input  logic                 i_q_full,
    output lrce_pkg::t_cmd       o_cmd,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic       r_mirror, n_mirror;
    logic       r_autocut, n_autocut;
    logic [7:0] r_media_width, n_media_width;
    logic       r_label_open, n_label_open;

    logic [7:0]                    pw;
    logic [lrce_pkg::PIX_BITS-1:0] pix;
    logic [lrce_pkg::PIX_BITS-1:0] pix_mask;
    logic signed [9:0]             margin;
    logic [8:0]                    shamt;
    logic [lrce_pkg::EXT_W-1:0]    ext;
    logic [lrce_pkg::EXT_W-1:0]    shifted;
    logic [lrce_pkg::ROW_BITS-1:0] row;
    logic [7:0]                    mode_byte;

    assign o_accept = i_push && !i_q_full;
    assign pw       = lrce_pkg::pixel_width(r_media_width);

    // place the column on the head, indexed by dot position
    always_comb begin
        pix = {i_item.dots_high, i_item.dots_low};
        for (int y = 0; y < lrce_pkg::PIX_BITS; y++) begin
            pix_mask[y] = (9'(y) < {1'b0, pw});
        end
        margin = 10'(lrce_pkg::HEAD_DOTS / 2) - $signed({3'b000, pw[7:1]});
        shamt  = margin[9] ? 9'(-margin) : margin[8:0];
        ext    = {{lrce_pkg::ROW_BITS{1'b0}}, pix & pix_mask};
        shifted = margin[9] ? (ext >> shamt) : (ext << shamt);
        for (int p = 0; p < lrce_pkg::ROW_BITS; p++) begin
            row[p] = shifted[p] && (p < lrce_pkg::HEAD_DOTS);
        end
    end

    assign mode_byte = (r_autocut ? lrce_pkg::BIT_AUTOCUT : 8'h00)
                     | (r_mirror  ? lrce_pkg::BIT_MIRROR  : 8'h00);

    always_comb begin
        n_label_open    = r_label_open;
        o_cmd.op        = lrce_pkg::OP_STATUS;
        o_cmd.data_byte = 8'h00;
        o_cmd.status    = lrce_pkg::ST_OK;
        o_cmd.row       = row;
        priority if (i_item.mode == lrce_pkg::MODE_JOB) begin
            o_cmd.op        = lrce_pkg::OP_HEADER;
            o_cmd.data_byte = mode_byte;
            n_label_open    = 1'b0;
        end else if (i_item.mode == lrce_pkg::MODE_LABEL) begin
            if (i_item.label_height != pw) begin
                o_cmd.status = lrce_pkg::ST_HEIGHT;
                n_label_open = 1'b0;
            end else if (i_item.label_length == 16'd0) begin
                o_cmd.status = lrce_pkg::ST_LENGTH;
                n_label_open = 1'b0;
            end else begin
                n_label_open = 1'b1;
            end
        end else if (!r_label_open) begin
            o_cmd.status = lrce_pkg::ST_CLOSED;
        end else if (i_item.mode == lrce_pkg::MODE_COLUMN) begin
            if (row == '0) begin
                o_cmd.op        = lrce_pkg::OP_BYTE;
                o_cmd.data_byte = lrce_pkg::CH_Z;
            end else begin
                o_cmd.op = lrce_pkg::OP_ROW;
            end
        end else begin
            o_cmd.op        = lrce_pkg::OP_BYTE;
            o_cmd.data_byte = i_item.final_label ? lrce_pkg::BYTE_EOJ : lrce_pkg::BYTE_FF;
            n_label_open    = 1'b0;
        end
        if (!o_accept) begin
            n_label_open = r_label_open;
        end
    end

    always_comb begin
        n_mirror      = r_mirror;
        n_autocut     = r_autocut;
        n_media_width = r_media_width;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lrce_pkg::CFG_MIRROR:  n_mirror      = i_cfg_data[0];
                lrce_pkg::CFG_AUTOCUT: n_autocut     = i_cfg_data[0];
                lrce_pkg::CFG_MEDIA:   n_media_width = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror      <= 1'b0;
            r_autocut     <= 1'b0;
            r_media_width <= lrce_pkg::MEDIA_RESET;
            r_label_open  <= 1'b0;
        end else begin
            r_mirror      <= n_mirror;
            r_autocut     <= n_autocut;
            r_media_width <= n_media_width;
            r_label_open  <= n_label_open;
        end
    end

endmodule

/* hw/rtl/lrce_queue.sv */
// Short command queue between the front and back ends.
// Depends on lrce_pkg for the command type and depth.
module lrce_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lrce_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output lrce_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    lrce_pkg::t_cmd          r_mem [lrce_pkg::QUEUE_DEPTH];
    logic [lrce_pkg::QPTR_W:0] r_wr_ptr, n_wr_ptr;
    logic [lrce_pkg::QPTR_W:0] r_rd_ptr, n_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[lrce_pkg::QPTR_W] != r_rd_ptr[lrce_pkg::QPTR_W])
                  && (r_wr_ptr[lrce_pkg::QPTR_W-1:0] == r_rd_ptr[lrce_pkg::QPTR_W-1:0]);
    assign o_cmd   = r_mem[r_rd_ptr[lrce_pkg::QPTR_W-1:0]];

    assign n_wr_ptr = r_wr_ptr + (lrce_pkg::QPTR_W + 1)'(i_push && !o_full);
    assign n_rd_ptr = r_rd_ptr + (lrce_pkg::QPTR_W + 1)'(i_pop && !o_empty);

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[lrce_pkg::QPTR_W-1:0]] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

endmodule

/* hw/rtl/lrce_back.sv */
// Back end: walks each queued command through its byte sequence into the
// result register. Depends on lrce_pkg.
module lrce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lrce_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output lrce_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);

    logic [lrce_pkg::STEP_W-1:0] r_step, n_step;
    lrce_pkg::t_result           r_out, n_out;
    logic                        r_out_valid, n_out_valid;

    logic                        emit;
    logic [lrce_pkg::STEP_W-1:0] seq_last;
    logic [lrce_pkg::STEP_W-1:0] data_idx;
    logic [7:0]                  row_byte;

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;
    assign emit     = !i_cmd_empty && (!r_out_valid || i_pop);
    assign data_idx = r_step - lrce_pkg::STEP_W'(4);

    always_comb begin
        row_byte = i_cmd.row[8 * data_idx[lrce_pkg::ROW_IDX_W-1:0] +: 8];
        // dot order is MSB first within the byte
        row_byte = {<<{row_byte}};
    end

    always_comb begin
        unique case (i_cmd.op)
            lrce_pkg::OP_HEADER: seq_last = lrce_pkg::STEP_W'(lrce_pkg::HEADER_LEN - 1);
            lrce_pkg::OP_ROW:    seq_last = lrce_pkg::STEP_W'(lrce_pkg::ROW_LEN - 1);
            default:             seq_last = '0;
        endcase
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        n_step      = r_step;
        o_cmd_pop   = 1'b0;
        if (emit) begin
            n_out_valid    = 1'b1;
            n_out.is_data  = 1'b1;
            n_out.status   = lrce_pkg::ST_OK;
            n_out.last     = (r_step == seq_last);
            unique case (i_cmd.op)
                lrce_pkg::OP_HEADER: n_out.out_byte =
                    lrce_pkg::header_byte(r_step, i_cmd.data_byte);
                lrce_pkg::OP_STATUS: begin
                    n_out.out_byte = 8'h00;
                    n_out.is_data  = 1'b0;
                    n_out.status   = i_cmd.status;
                end
                lrce_pkg::OP_BYTE: n_out.out_byte = i_cmd.data_byte;
                lrce_pkg::OP_ROW: begin
                    priority if (r_step == lrce_pkg::STEP_W'(0)) begin
                        n_out.out_byte = lrce_pkg::CH_G;
                    end else if (r_step == lrce_pkg::STEP_W'(1)) begin
                        n_out.out_byte = lrce_pkg::ROW_CNT_LO;
                    end else if (r_step == lrce_pkg::STEP_W'(2)) begin
                        n_out.out_byte = lrce_pkg::ROW_CNT_HI;
                    end else if (r_step == lrce_pkg::STEP_W'(3)) begin
                        n_out.out_byte = lrce_pkg::ROW_CNT_LAST;
                    end else begin
                        n_out.out_byte = row_byte;
                    end
                end
                default: n_out.out_byte = 8'h00;
            endcase
            // retire the command on its final word
            if (r_step == seq_last) begin
                o_cmd_pop = 1'b1;
                n_step    = '0;
            end else begin
                n_step = r_step + lrce_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= lrce_pkg::STEP_W'(lrce_pkg::SEQ_LEN - 1))
        else $error("sequence step out of range");

    a_mid_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != '0 |-> !i_cmd_empty)
        else $error("command left the queue before its last word");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.is_data |-> r_out.last && r_out.out_byte == 8'h00)
        else $error("status word not final or carries a byte");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_data |-> r_out.status == lrce_pkg::ST_OK)
        else $error("stream word with nonzero status");

endmodule

/* hw/rtl/label_raster_column_encoder.sv */
// Top level of the label raster column encoder.
// Depends on lrce_pkg, lrce_front, lrce_queue and lrce_back.
//
// Usage:
//   Input words (job start, label start, pixel column, label end) enter on
//   push/full/i_item; a word is taken when push is high and full is low.
//   Results leave on empty/pop/o_result; the oldest result sits on o_result
//   while empty is low and is taken when pop is high.
//   Configuration (mirror, autocut, media width) is written on i_cfg_valid,
//   i_cfg_index, i_cfg_data; o_cfg_ready is always high. Write it only while
//   the block is idle.
// Timing:
//   A word is classified in the cycle it is taken and queued (four entries);
//   its first result passes from the queue into the result register when the
//   path is clear. The back end sends one result per cycle while the receiver
//   takes them: 14 for a job header, 20 for a non-blank column, one for
//   everything else, so the byte-wide result port paces a stream of columns.
// Reset clears the configuration (media width 12 mm), closes any label and
// empties the queue and the result register. When the receiver stalls the
// result holds, the queue fills and full rises; no word is lost.
module label_raster_column_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  lrce_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output lrce_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    logic           accept;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    lrce_pkg::t_cmd front_cmd;
    lrce_pkg::t_cmd head_cmd;

    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    lrce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_accept    (accept),
        .i_q_full    (q_full),
        .o_cmd       (front_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lrce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    lrce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
